// ===== hw/rtl/drf_pkg.sv =====
`timescale 1ns / 1ps

package drf_pkg;

    localparam int unsigned WORD_W  = 24;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned KEY_W   = 48;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [HALF_W-1:0] IV_LEFT_RST  = 32'hef926535;
    localparam logic [HALF_W-1:0] IV_RIGHT_RST = 32'h89793238;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IV_LEFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IV_RIGHT = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] msg_word0;
        logic [WORD_W-1:0] msg_word1;
        logic [WORD_W-1:0] msg_word2;
        logic [WORD_W-1:0] msg_word3;
        logic [WORD_W-1:0] msg_word4;
    } msg_t;

    typedef struct packed {
        logic [HALF_W-1:0] hash_left;
        logic [HALF_W-1:0] hash_right;
    } hash_t;

    // expansion E, bit 1 is the MSB
    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // permutation P, bit 1 is the MSB
    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // S-boxes: 64 nibbles each, entry row*16+col, entry 0 in the top nibble
    localparam logic [255:0] SBOX_TAB [8] = '{
        {64'he4d12fb83a6c5907, 64'h0f74e2d1a6cb9538,
         64'h41e8d62bfc973a50, 64'hfc8249175b3ea06d},
        {64'hf18e6b34972dc05a, 64'h3d47f28ec01a69b5,
         64'h0e7ba4d158c6932f, 64'hd8a13f42b67c05e9},
        {64'ha09e63f51dc7b428, 64'hd709346a285ecbf1,
         64'hd6498f30b12c5ae7, 64'h1ad069874fe3b52c},
        {64'h7de3069a1285bc4f, 64'hd8b56f03472c1ae9,
         64'ha690cb7df13e5284, 64'h3f06a1d8945bc72e},
        {64'h2c417ab6853fd0e9, 64'heb2c47d150fa3986,
         64'h421bad78f9c5630e, 64'hb8c71e2d6f09a453},
        {64'hc1af92680d34e75b, 64'haf427c9561de0b38,
         64'h9ef528c3704a1db6, 64'h432c95fabe17608d},
        {64'h4b2ef08d3c975a61, 64'hd0b7491ae35c2f86,
         64'h14bdc37eaf680592, 64'h6bd814a7950fe23c},
        {64'hd2846fb1a93e50c7, 64'h1fd8a374c56b0e92,
         64'h7b419ce206adf358, 64'h21e74a8dfc90356b}
    };

    // row from the outer bits, column from the inner four
    function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [5:0] chunk);
        logic [5:0] idx;
        idx = {chunk[5], chunk[0], chunk[4:1]};
        return SBOX_TAB[box][{~idx, 2'b11} -: 4];
    endfunction

endpackage

// ===== hw/rtl/des_round_hash_120bit.sv =====
`timescale 1ns / 1ps

// Four-round DES-style Feistel hash of a 120-bit message into 64 bits.
//
// Request channel msg/msg_valid/msg_ready carries five 24-bit message words;
// result channel hash/hash_valid/hash_ready returns the left and right halves.
// Both use valid/ready: a transfer happens on a clock edge with both high.
//
// The block is a two-register pipeline: an input register holds the request,
// the four F-function rounds run combinationally from it, and the hash is
// captured in an output register, which takes it from the input register as
// soon as it is empty or being drained; throughput is one request per cycle
// while the receiver keeps hash_ready high, set by the single pass through
// the four rounds between those two registers.
//
// When the receiver stalls (hash_ready low) the output register holds its
// hash, the input register fills, and then msg_ready drops; nothing is lost.
// Reset (rst_n low, asynchronous) empties both registers and loads the
// initial halves with their defaults. cfg_wr_en writes iv_left (index 0) or
// iv_right (index 1); write them only while no request is in flight.

module des_round_hash_120bit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [drf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drf_pkg::HALF_W-1:0]    cfg_data,

    input  logic                          msg_valid,
    output logic                          msg_ready,
    input  drf_pkg::msg_t                 msg,

    output logic                          hash_valid,
    input  logic                          hash_ready,
    output drf_pkg::hash_t                hash
);

    logic [drf_pkg::HALF_W-1:0] iv_left_reg;
    logic [drf_pkg::HALF_W-1:0] iv_right_reg;

    drf_pkg::msg_t  msg_reg;
    logic           msg_vld_reg;
    logic           msg_vld_next;
    drf_pkg::hash_t hash_reg;
    logic           hash_vld_reg;
    logic           hash_vld_next;
    drf_pkg::hash_t hash_next;
    logic           hash_adv;
    logic           msg_take;

    // Configuration registers: plain writes, unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_left_reg  <= drf_pkg::IV_LEFT_RST;
            iv_right_reg <= drf_pkg::IV_RIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                drf_pkg::REG_IV_LEFT:  iv_left_reg  <= cfg_data;
                drf_pkg::REG_IV_RIGHT: iv_right_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Output register advances when empty or being drained; the input
    // register advances when empty or whenever the output register can take its content.
    assign hash_adv  = !hash_vld_reg || hash_ready;
    assign msg_ready = !msg_vld_reg || hash_adv;
    assign msg_take  = msg_valid && msg_ready;

    assign msg_vld_next  = msg_ready ? msg_valid : msg_vld_reg;
    assign hash_vld_next = hash_adv ? msg_vld_reg : hash_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_vld_reg  <= 1'b0;
            hash_vld_reg <= 1'b0;
        end
        else
        begin
            msg_vld_reg  <= msg_vld_next;
            hash_vld_reg <= hash_vld_next;
        end
    end

    // Payload registers: capture only on a transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (msg_take)
        begin
            msg_reg <= msg;
        end
        if (hash_adv && msg_vld_reg)
        begin
            hash_reg <= hash_next;
        end
    end

    // Four Feistel rounds from the held request.
    drf_rounds u_rounds
    (
        .msg      (msg_reg),
        .iv_left  (iv_left_reg),
        .iv_right (iv_right_reg),
        .hash     (hash_next)
    );

    assign hash_valid = hash_vld_reg;
    assign hash       = hash_reg;

endmodule

// ===== hw/rtl/drf_f.sv =====
`timescale 1ns / 1ps

module drf_f
(
    input  logic [drf_pkg::HALF_W-1:0] r,
    input  logic [drf_pkg::KEY_W-1:0]  key,
    output logic [drf_pkg::HALF_W-1:0] f_out
);

    logic [drf_pkg::KEY_W-1:0]  ex;
    logic [drf_pkg::KEY_W-1:0]  exk;
    logic [drf_pkg::HALF_W-1:0] sout;

    // expand to 48 bits
    always_comb
    begin
        for (int i = 0; i < 48; i++)
        begin
            ex[47-i] = r[5'(6'd32 - drf_pkg::E_TAB[i])];
        end
    end

    assign exk = ex ^ key;

    // eight S-boxes, box 1 in the top nibble
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sout[31-4*i -: 4] = drf_pkg::sbox_lookup(3'(i), exk[47-6*i -: 6]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            f_out[31-i] = sout[5'(6'd32 - drf_pkg::P_TAB[i])];
        end
    end

endmodule

// ===== hw/rtl/drf_rounds.sv =====
`timescale 1ns / 1ps

module drf_rounds
(
    input  drf_pkg::msg_t              msg,
    input  logic [drf_pkg::HALF_W-1:0] iv_left,
    input  logic [drf_pkg::HALF_W-1:0] iv_right,
    output drf_pkg::hash_t             hash
);

    logic [drf_pkg::KEY_W-1:0]  key0;
    logic [drf_pkg::KEY_W-1:0]  key1;
    logic [drf_pkg::KEY_W-1:0]  key2;
    logic [drf_pkg::HALF_W-1:0] f1;
    logic [drf_pkg::HALF_W-1:0] f2;
    logic [drf_pkg::HALF_W-1:0] f3;
    logic [drf_pkg::HALF_W-1:0] f4;
    logic [drf_pkg::HALF_W-1:0] r1;
    logic [drf_pkg::HALF_W-1:0] r2;
    logic [drf_pkg::HALF_W-1:0] r3;

    assign key0 = {msg.msg_word0, msg.msg_word0};
    assign key1 = {msg.msg_word1, msg.msg_word2};
    assign key2 = {msg.msg_word3, msg.msg_word4};

    drf_f u_f1 (.r(iv_right), .key(key0), .f_out(f1));
    assign r1 = iv_left ^ f1;

    drf_f u_f2 (.r(r1), .key(key1), .f_out(f2));
    assign r2 = iv_right ^ f2;

    drf_f u_f3 (.r(r2), .key(key2), .f_out(f3));
    assign r3 = r1 ^ f3;

    // last round keeps the halves in place
    drf_f u_f4 (.r(r3), .key(key0), .f_out(f4));

    assign hash.hash_left  = r2 ^ f4;
    assign hash.hash_right = r3;

endmodule

// ===== hw/rtl/drf_checker.sv =====
`timescale 1ns / 1ps

module drf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          msg_valid,
    input logic                          msg_ready,
    input logic                          hash_valid,
    input logic                          hash_ready,
    input drf_pkg::hash_t                hash
);

    // a stalled hash holds
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> hash_valid && $stable(hash))
        else $error("hash changed or dropped while stalled");

    // an empty output side never blocks a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !hash_valid |-> msg_ready)
        else $error("request blocked with empty output");

    // a request taken into an empty output side reaches hash_valid through the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !hash_valid |=> ##1 hash_valid)
        else $error("hash missing two cycles after request");

    // a hash appears only after a request was taken through the input register
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(msg_valid && msg_ready, 2))
        else $error("hash without a request");

endmodule

bind des_round_hash_120bit drf_checker u_drf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash       (hash)
);

// ===== bench/des_round_hash_120bit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the four-round Feistel hash.
//
// Requests carry five 24-bit message words; every accepted request yields exactly
// one 64-bit hash, in order. The bench keeps its own copy of the DES F function
// and of the two initial halves, queues the hash each accepted request should
// produce, and checks every hash leaving the block against the oldest entry.

module des_round_hash_120bit_tb;

    localparam int RESET_CYCLES   = 8;
    localparam int MAX_GAP        = 18;
    localparam int STALL_LIMIT    = 2000;  // cycles with no transfer on either side
    localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch
    localparam int SETTLE         = 4;     // margin for the last hash to leave the block
    localparam int PHASES         = 8;
    localparam int RAND_PER_PHASE = 222;

    localparam logic [31:0] IV_LEFT_INIT  = 32'hef926535;
    localparam logic [31:0] IV_RIGHT_INIT = 32'h89793238;

    // permutation P, one 6-bit source position per output bit, MSB = position 1
    localparam logic [191:0] P_SRC = {
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_mode_e;

    // Tracks the initial halves and the hashes still owed by the block.
    class hash_tracker;
        logic [31:0]    iv_left;
        logic [31:0]    iv_right;
        drf_pkg::hash_t hash_due[$];
        int             mismatches;

        function new();
            iv_left    = IV_LEFT_INIT;
            iv_right   = IV_RIGHT_INIT;
            mismatches = 0;
        endfunction

        function void set_iv(logic [drf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == drf_pkg::REG_IV_LEFT)
                iv_left = value;
            else if (idx == drf_pkg::REG_IV_RIGHT)
                iv_right = value;
        endfunction

        // Rows of 16 nibbles, column 0 in the top nibble of each row.
        function logic [3:0] sbox_nibble(int box, logic [5:0] chunk);
            logic [255:0] tab;
            logic [5:0]   idx;
            case (box)
                0: tab = {64'he4d12fb83a6c5907, 64'h0f74e2d1a6cb9538,
                          64'h41e8d62bfc973a50, 64'hfc8249175b3ea06d};
                1: tab = {64'hf18e6b34972dc05a, 64'h3d47f28ec01a69b5,
                          64'h0e7ba4d158c6932f, 64'hd8a13f42b67c05e9};
                2: tab = {64'ha09e63f51dc7b428, 64'hd709346a285ecbf1,
                          64'hd6498f30b12c5ae7, 64'h1ad069874fe3b52c};
                3: tab = {64'h7de3069a1285bc4f, 64'hd8b56f03472c1ae9,
                          64'ha690cb7df13e5284, 64'h3f06a1d8945bc72e};
                4: tab = {64'h2c417ab6853fd0e9, 64'heb2c47d150fa3986,
                          64'h421bad78f9c5630e, 64'hb8c71e2d6f09a453};
                5: tab = {64'hc1af92680d34e75b, 64'haf427c9561de0b38,
                          64'h9ef528c3704a1db6, 64'h432c95fabe17608d};
                6: tab = {64'h4b2ef08d3c975a61, 64'hd0b7491ae35c2f86,
                          64'h14bdc37eaf680592, 64'h6bd814a7950fe23c};
                default: tab = {64'hd2846fb1a93e50c7, 64'h1fd8a374c56b0e92,
                                64'h7b419ce206adf358, 64'h21e74a8dfc90356b};
            endcase
            // row from the two outer bits, column from the middle four
            idx = {chunk[5], chunk[0], chunk[4:1]};
            return tab[255 - 4*idx -: 4];
        endfunction

        function logic [31:0] des_f(logic [31:0] r, logic [47:0] key);
            logic [47:0] ex;
            logic [31:0] sout;
            logic [31:0] res;
            int          src;
            // expansion: group g takes positions 4g..4g+5, wrapping 0 to 32 and 33 to 1
            for (int i = 0; i < 48; i++)
            begin
                src = ((4*(i/6) + i%6 + 31) % 32) + 1;
                ex[47-i] = r[32-src];
            end
            ex ^= key;
            for (int i = 0; i < 8; i++)
                sout[31-4*i -: 4] = sbox_nibble(i, ex[47-6*i -: 6]);
            for (int i = 0; i < 32; i++)
                res[31-i] = sout[32 - P_SRC[191-6*i -: 6]];
            return res;
        endfunction

        function drf_pkg::hash_t feistel_hash(drf_pkg::msg_t m);
            logic [2:0][47:0] keys;
            logic [31:0]      l;
            logic [31:0]      r;
            logic [31:0]      t;
            drf_pkg::hash_t   h;
            keys[0] = {m.msg_word0, m.msg_word0};
            keys[1] = {m.msg_word1, m.msg_word2};
            keys[2] = {m.msg_word3, m.msg_word4};
            l = iv_left;
            r = iv_right;
            for (int k = 0; k < 3; k++)
            begin
                t = r;
                r = l ^ des_f(r, keys[k]);
                l = t;
            end
            // last round reuses the first key and keeps the halves in place
            l ^= des_f(r, keys[0]);
            h.hash_left  = l;
            h.hash_right = r;
            return h;
        endfunction

        function void take_msg(drf_pkg::msg_t m);
            hash_due.push_back(feistel_hash(m));
        endfunction

        function void match_hash(drf_pkg::hash_t got);
            drf_pkg::hash_t want;
            if (hash_due.size() == 0)
            begin
                $display("%0t: hash with no request pending, expected none actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = hash_due.pop_front();
            if (got.hash_left !== want.hash_left)
            begin
                $display("%0t: hash_left mismatch, expected %h actual %h",
                         $time, want.hash_left, got.hash_left);
                mismatches++;
            end
            if (got.hash_right !== want.hash_right)
            begin
                $display("%0t: hash_right mismatch, expected %h actual %h",
                         $time, want.hash_right, got.hash_right);
                mismatches++;
            end
        endfunction

        function int pending();
            return hash_due.size();
        endfunction
    endclass

    // Drive every input to a known value from time zero.
    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          cfg_wr_en  = 1'b0;
    logic [drf_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [drf_pkg::HALF_W-1:0]    cfg_data   = '0;
    logic                          msg_valid  = 1'b0;
    logic                          msg_ready;
    drf_pkg::msg_t                 msg        = '0;
    logic                          hash_valid;
    logic                          hash_ready = 1'b0;
    drf_pkg::hash_t                hash;

    idle_mode_e  valid_mode  = IDLE_RANDOM;
    idle_mode_e  ready_mode  = IDLE_RANDOM;
    int          hold_cycles = 0;   // one-shot long stall, picked up by the receiver
    hash_tracker book = new();

    des_round_hash_120bit uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .msg        (msg),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash       (hash)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Pick the idle cycles before the next transfer on one side.
    function automatic int draw_gap(idle_mode_e mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:     return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // Bias toward all-zero and all-one words; the rest is uniform.
    function automatic logic [drf_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return 24'($urandom_range(0, 24'hffffff));
        endcase
    endfunction

    function automatic logic [31:0] rand_half();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic drf_pkg::msg_t rand_msg();
        return '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Corner messages: zeros, ones, alternating bits, one word live at a time, and a mixed edge-bit pattern.
    function automatic drf_pkg::msg_t directed_msg(int k);
        case (k)
            0:       return '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
            1:       return '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff};
            2:       return '{24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa};
            3:       return '{24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555};
            4:       return '{24'hffffff, 24'h000000, 24'h000000, 24'h000000, 24'h000000};
            5:       return '{24'h000000, 24'hffffff, 24'h000000, 24'h000000, 24'h000000};
            6:       return '{24'h000000, 24'h000000, 24'hffffff, 24'h000000, 24'h000000};
            7:       return '{24'h000000, 24'h000000, 24'h000000, 24'hffffff, 24'h000000};
            8:       return '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'hffffff};
            default: return '{24'h800001, 24'h000001, 24'h800000, 24'h7ffffe, 24'hfffffe};
        endcase
    endfunction

    // Offer one request after the given idle gap and hold it until accepted.
    // Keep valid high across back-to-back requests; drop it only for a gap.
    task automatic send_msg(input drf_pkg::msg_t m, input int gap);
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= m;
        @(posedge clk);
        while (!msg_ready) @(posedge clk);
        book.take_msg(m);
    endtask

    // Stop offering, wait for every owed hash, then let the pipeline settle.
    task automatic drain();
        msg_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write the selected initial halves back to back; only call when idle.
    task automatic program_iv(input bit do_left, input bit do_right,
                              input logic [31:0] left_val, input logic [31:0] right_val);
        if (do_left)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= drf_pkg::REG_IV_LEFT;
            cfg_data  <= left_val;
            @(posedge clk);
            book.set_iv(drf_pkg::REG_IV_LEFT, left_val);
        end
        if (do_right)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= drf_pkg::REG_IV_RIGHT;
            cfg_data  <= right_val;
            @(posedge clk);
            book.set_iv(drf_pkg::REG_IV_RIGHT, right_val);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: stall a drawn number of cycles before each hash, then take it.
    // A pending long hold replaces the drawn stall once, so the block backs up.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(ready_mode);
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                hash_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hash_ready <= 1'b1;
            @(posedge clk);
            while (!hash_valid) @(posedge clk);
            book.match_hash(hash);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (msg_valid && msg_ready) || (hash_valid && hash_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: directed corners under three settings, then random phases.
    initial
    begin
        bit          do_left;
        bit          do_right;
        logic [31:0] left_val;
        logic [31:0] right_val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset halves, full corner set
        for (int k = 0; k < 10; k++)
            send_msg(directed_msg(k), draw_gap(valid_mode));

        // both halves cleared
        drain();
        program_iv(1'b1, 1'b1, 32'h00000000, 32'h00000000);
        for (int k = 0; k < 6; k++)
            send_msg(directed_msg(k), draw_gap(valid_mode));

        // both halves all ones
        drain();
        program_iv(1'b1, 1'b1, 32'hffffffff, 32'hffffffff);
        for (int k = 0; k < 6; k++)
            send_msg(directed_msg(k), draw_gap(valid_mode));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            // rewrite one half or both, so each register is seen changing alone
            case ($urandom_range(0, 2))
                0:       begin do_left = 1'b1; do_right = 1'b0; end
                1:       begin do_left = 1'b0; do_right = 1'b1; end
                default: begin do_left = 1'b1; do_right = 1'b1; end
            endcase
            left_val  = rand_half();
            right_val = rand_half();
            program_iv(do_left, do_right, left_val, right_val);

            case (p)
                0:       begin valid_mode = IDLE_NONE;   ready_mode = IDLE_NONE;   end
                1:       begin valid_mode = IDLE_RANDOM; ready_mode = IDLE_RANDOM; end
                2:       begin valid_mode = IDLE_SPARSE; ready_mode = IDLE_SPARSE; end
                default:
                begin
                    valid_mode = idle_mode_e'($urandom_range(0, 2));
                    ready_mode = idle_mode_e'($urandom_range(0, 2));
                end
            endcase
            // hold off the receiver while requests keep coming
            if (p == 2)
                hold_cycles = LONG_HOLD;

            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                // pause the sender mid-phase until every hash is back
                if (p == 3 && i == RAND_PER_PHASE/2)
                begin
                    msg_valid <= 1'b0;
                    while (book.pending() != 0) @(posedge clk);
                end
                send_msg(rand_msg(), draw_gap(valid_mode));
            end
        end

        drain();
        repeat (2*SETTLE) @(posedge clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
